@@ rtl/core/sfla_pkg.sv @@
package sfla_pkg;

    // Default depth of the slab
    localparam int MAX_OBJECTS_DEF = 256;
    // Allocated addresses wrap at this many bits before they leave the block
    localparam int ADDRESS_BITS = 24;

    localparam int BASE_W      = 24;
    localparam int SIZE_W      = 16;
    localparam int COUNT_W     = 9;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int INDEX_OUT_W = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // Divider steps: one quotient bit per cycle
    localparam int DIV_STEPS = BASE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISALIGNED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_COUNT = 2'd2;

    localparam logic [BASE_W-1:0]  BASE_RESET  = 24'd0;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 16'd16;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    typedef struct packed {
        logic load;       // capture the word
        logic mul;        // run the multiplier, read the link at the head
        logic chk;        // range check of a free, start the divider
        logic init_step;  // write one link of the initial chain
        logic finish;     // update head and count, register the result
    } sfla_cmd_t;

    typedef struct packed {
        logic range_bad;
        logic div_done;
        logic init_last;
    } sfla_stat_t;

endpackage

@@ rtl/core/slab_free_list_allocator_core.sv @@
// Channel   Handshake               Payload
// command   start, busy             opcode, free_address
// result    done (one-cycle pulse)  status, object_address, object_index,
//                                   allocated_count, is_empty, is_full
// config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// One word at a time. Allocate: multiply, then finish. Free: multiply, check,
// then the bit-serial divider (one quotient bit per cycle, 24 bits), then
// finish; an address outside the slab skips the divider wait. Initialize:
// one link written per cycle up to the effective count (count 0 acts as 1,
// above the depth as the depth), then finish. Other opcodes go straight to finish.
// Reset empties the list, zeroes the live count and restores config defaults;
// the link store is not cleared. done is high for one cycle and cannot be held off.
module slab_free_list_allocator_core
    import sfla_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [OP_W-1:0]        opcode,
    input  logic [BASE_W-1:0]      free_address,
    output logic                   done,
    output logic [STATUS_W-1:0]    status,
    output logic [BASE_W-1:0]      object_address,
    output logic [INDEX_OUT_W-1:0] object_index,
    output logic [COUNT_W-1:0]     allocated_count,
    output logic                   is_empty,
    output logic                   is_full,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    sfla_cmd_t  cmd;
    sfla_stat_t stat;

    sfla_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    sfla_dpath #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .opcode          (opcode),
        .free_address    (free_address),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .status          (status),
        .object_address  (object_address),
        .object_index    (object_index),
        .allocated_count (allocated_count),
        .is_empty        (is_empty),
        .is_full         (is_full)
    );

endmodule

@@ rtl/core/sfla_div.sv @@
module sfla_div
    import sfla_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [BASE_W-1:0] dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [BASE_W-1:0] quotient,
    output logic [SIZE_W-1:0] remainder
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [BASE_W-1:0]    quo_reg, quo_next;
    logic [SIZE_W-1:0]    rem_reg, rem_next;
    logic [SIZE_W:0]      trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = done_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, quo_reg[BASE_W-1]};
        if (start)
        begin
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            done_next = 1'b0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (cnt_reg != '0)
        begin
            // shift in the next dividend bit, subtract where it fits
            if (trial >= {1'b0, divisor})
            begin
                rem_next = SIZE_W'(trial - {1'b0, divisor});
                quo_next = {quo_reg[BASE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[SIZE_W-1:0];
                quo_next = {quo_reg[BASE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/core/sfla_dpath.sv @@
module sfla_dpath
    import sfla_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sfla_cmd_t              cmd,
    output sfla_stat_t             stat,
    input  logic [OP_W-1:0]        opcode,
    input  logic [BASE_W-1:0]      free_address,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   done,
    output logic [STATUS_W-1:0]    status,
    output logic [BASE_W-1:0]      object_address,
    output logic [INDEX_OUT_W-1:0] object_index,
    output logic [COUNT_W-1:0]     allocated_count,
    output logic                   is_empty,
    output logic                   is_full
);

    localparam int IDX_W  = $clog2(MAX_OBJECTS);
    localparam int LNK_W  = $clog2(MAX_OBJECTS + 1);
    localparam int PROD_W = IDX_W + SIZE_W;
    localparam int SUM_W  = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 1;
    localparam logic [LNK_W-1:0] NIL = LNK_W'(MAX_OBJECTS);

    logic [BASE_W-1:0]  object_base_reg;
    logic [SIZE_W-1:0]  object_size_reg;
    logic [COUNT_W-1:0] object_count_reg;

    logic [LNK_W-1:0]   head_reg, head_next;
    logic [LNK_W-1:0]   live_reg, live_next;
    logic               done_reg;
    logic               range_bad_reg;
    logic [IDX_W-1:0]   init_idx_reg;

    logic [OP_W-1:0]    op_reg;
    logic [BASE_W-1:0]  addr_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [LNK_W-1:0]   link_rd_reg;

    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [BASE_W-1:0]      oaddr_reg, oaddr_next;
    logic [INDEX_OUT_W-1:0] oidx_reg, oidx_next;
    logic [COUNT_W-1:0]     count_out_reg;
    logic                   empty_reg, full_reg;

    logic [LNK_W-1:0]   link_mem [MAX_OBJECTS];

    logic [LNK_W-1:0]   cnt_eff;
    logic [LNK_W-1:0]   cnt_m1;
    logic [SIZE_W-1:0]  size_eff;
    logic [IDX_W-1:0]   mul_a;
    logic [SUM_W-1:0]   sum;
    logic [BASE_W-1:0]  diff;
    logic               range_bad;
    logic               head_ok;
    logic               init_last;
    logic               push;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [LNK_W-1:0]   mem_wd;
    logic               div_done;
    logic [BASE_W-1:0]  div_quo;
    logic [SIZE_W-1:0]  div_rem;
    logic [IDX_W-1:0]   q_idx;

    // count 0 acts as 1, counts above the depth act as the depth
    always_comb
    begin
        if (object_count_reg == '0)
        begin
            cnt_eff = LNK_W'(1);
        end
        else if (32'(object_count_reg) > 32'(MAX_OBJECTS))
        begin
            cnt_eff = NIL;
        end
        else
        begin
            cnt_eff = LNK_W'(object_count_reg);
        end
    end

    assign cnt_m1    = cnt_eff - 1'b1;
    assign size_eff  = (object_size_reg == '0) ? SIZE_W'(1) : object_size_reg;
    assign mul_a     = (op_reg == OP_ALLOC) ? head_reg[IDX_W-1:0] : cnt_m1[IDX_W-1:0];
    assign sum       = SUM_W'(object_base_reg) + SUM_W'(prod_reg);
    assign diff      = addr_reg - object_base_reg;
    assign range_bad = (addr_reg < object_base_reg) || (SUM_W'(addr_reg) > sum);
    assign head_ok   = head_reg < cnt_eff;
    assign init_last = (LNK_W'(init_idx_reg) == cnt_m1);
    assign q_idx     = div_quo[IDX_W-1:0];
    assign push      = cmd.finish && (op_reg == OP_FREE) && !range_bad_reg
                       && (div_rem == '0);

    assign stat.range_bad = range_bad_reg;
    assign stat.div_done  = div_done;
    assign stat.init_last = init_last;

    sfla_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.chk),
        .dividend  (diff),
        .divisor   (size_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // link store write port: initial chain or a push on free
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = init_idx_reg;
        mem_wd = init_last ? NIL : LNK_W'(init_idx_reg) + 1'b1;
        if (cmd.init_step)
        begin
            mem_we = 1'b1;
        end
        else if (push)
        begin
            mem_we = 1'b1;
            mem_wa = q_idx;
            mem_wd = head_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_wa] <= mem_wd;
        end
        if (cmd.mul)
        begin
            link_rd_reg <= link_mem[head_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        head_next   = head_reg;
        live_next   = live_reg;
        status_next = ST_OK;
        oaddr_next  = '0;
        oidx_next   = '0;
        case (op_reg)
            OP_ALLOC:
            begin
                if (head_ok)
                begin
                    for (int i = 0; i < BASE_W; i++)
                    begin
                        oaddr_next[i] = sum[i] && (i < ADDRESS_BITS);
                    end
                    oidx_next = INDEX_OUT_W'(head_reg);
                    head_next = link_rd_reg;
                    if (live_reg < cnt_eff)
                    begin
                        live_next = live_reg + 1'b1;
                    end
                end
                else
                begin
                    status_next = ST_NO_FREE;
                end
            end
            OP_FREE:
            begin
                if (range_bad_reg)
                begin
                    status_next = ST_OUTSIDE;
                end
                else if (div_rem != '0)
                begin
                    status_next = ST_MISALIGNED;
                end
                else
                begin
                    head_next = LNK_W'(q_idx);
                    oidx_next = INDEX_OUT_W'(q_idx);
                    if (live_reg != '0)
                    begin
                        live_next = live_reg - 1'b1;
                    end
                end
            end
            OP_INIT:
            begin
                head_next = '0;
                live_next = '0;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            object_base_reg  <= BASE_RESET;
            object_size_reg  <= SIZE_RESET;
            object_count_reg <= COUNT_RESET;
            head_reg         <= NIL;
            live_reg         <= '0;
            done_reg         <= 1'b0;
            range_bad_reg    <= 1'b0;
            init_idx_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OBJECT_BASE:  object_base_reg  <= BASE_W'(cfg_data);
                    REG_OBJECT_SIZE:  object_size_reg  <= SIZE_W'(cfg_data);
                    REG_OBJECT_COUNT: object_count_reg <= COUNT_W'(cfg_data);
                    default:          object_base_reg  <= object_base_reg;
                endcase
            end
            done_reg <= cmd.finish;
            if (cmd.load)
            begin
                init_idx_reg <= '0;
            end
            else if (cmd.init_step)
            begin
                init_idx_reg <= init_idx_reg + 1'b1;
            end
            if (cmd.chk)
            begin
                range_bad_reg <= range_bad;
            end
            if (cmd.finish)
            begin
                head_reg <= head_next;
                live_reg <= live_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            addr_reg <= free_address;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(size_eff);
        end
        if (cmd.finish)
        begin
            status_reg    <= status_next;
            oaddr_reg     <= oaddr_next;
            oidx_reg      <= oidx_next;
            count_out_reg <= COUNT_W'(live_next);
            empty_reg     <= (live_next == '0);
            full_reg      <= (live_next == cnt_eff);
        end
    end

    assign cfg_ready       = 1'b1;
    assign done            = done_reg;
    assign status          = status_reg;
    assign object_address  = oaddr_reg;
    assign object_index    = oidx_reg;
    assign allocated_count = count_out_reg;
    assign is_empty        = empty_reg;
    assign is_full         = full_reg;

endmodule

@@ rtl/core/sfla_ctrl.sv @@
module sfla_ctrl
    import sfla_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] opcode,
    input  sfla_stat_t      stat,
    output sfla_cmd_t       cmd,
    output logic            busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_INIT = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [OP_W-1:0] op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    op_next  = opcode;
                    case (opcode)
                        OP_ALLOC: state_next = S_MUL;
                        OP_FREE:  state_next = S_MUL;
                        OP_INIT:  state_next = S_INIT;
                        default:  state_next = S_FIN;
                    endcase
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = (op_reg == OP_FREE) ? S_CHK : S_FIN;
            end
            S_CHK:
            begin
                cmd.chk    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // leave when the divider is done, or early when the address lies outside the slab
                if (stat.range_bad || stat.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (stat.init_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_ALLOC;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ verif/slab_checker.sv @@
module slab_checker
    import sfla_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [OP_W-1:0]        opcode,
    input  logic [BASE_W-1:0]      free_address,
    input  logic                   done,
    input  logic [STATUS_W-1:0]    status,
    input  logic [BASE_W-1:0]      object_address,
    input  logic [INDEX_OUT_W-1:0] object_index,
    input  logic [COUNT_W-1:0]     allocated_count,
    input  logic                   is_empty,
    input  logic                   is_full,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     outstanding,
    output int                     fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLAB_DEPTH = MAX_OBJECTS_DEF;

    typedef struct {
        logic [STATUS_W-1:0]    status;
        logic [BASE_W-1:0]      address;
        logic [INDEX_OUT_W-1:0] index;
        logic [COUNT_W-1:0]     live;
        logic                   empty;
        logic                   full;
    } slab_result_t;

    logic [COUNT_W-1:0] link_mem [SLAB_DEPTH];
    logic [COUNT_W-1:0] head;
    logic [COUNT_W-1:0] live;
    logic [BASE_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [COUNT_W-1:0] count_reg;
    slab_result_t       expected_results[$];
    int                 errors;

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        errors++;
    endtask

    function automatic slab_result_t slab_apply(logic [OP_W-1:0] op, logic [BASE_W-1:0] addr);
        slab_result_t    r;
        longint unsigned n;
        longint unsigned sz;
        longint unsigned a;
        longint unsigned last;
        longint unsigned diff;
        longint unsigned idx;
        n  = (count_reg == 0) ? 1 : ((count_reg > SLAB_DEPTH) ? SLAB_DEPTH : count_reg);
        sz = (size_reg == 0) ? 1 : size_reg;
        r.status  = ST_OK;
        r.address = '0;
        r.index   = '0;
        case (op)
            OP_INIT: begin
                for (int i = 0; i < n; i++)
                    link_mem[i] = (i + 1 < n) ? COUNT_W'(i + 1) : COUNT_W'(SLAB_DEPTH);
                head = '0;
                live = '0;
            end
            OP_ALLOC: begin
                // an empty list and a head beyond a lowered count both refuse
                if (head >= n) begin
                    r.status = ST_NO_FREE;
                end else begin
                    a         = base_reg + longint'(head) * sz;
                    r.address = a[BASE_W-1:0];
                    r.index   = head[INDEX_OUT_W-1:0];
                    head      = link_mem[head];
                    if (live < n)
                        live++;
                end
            end
            OP_FREE: begin
                last = base_reg + (n - 1) * sz;
                if (addr < base_reg || addr > last) begin
                    r.status = ST_OUTSIDE;
                end else begin
                    diff = addr - base_reg;
                    if (diff % sz != 0) begin
                        r.status = ST_MISALIGNED;
                    end else begin
                        // double free goes through: push again, floor the count at 0
                        idx           = diff / sz;
                        link_mem[idx] = head;
                        head          = COUNT_W'(idx);
                        r.index       = INDEX_OUT_W'(idx);
                        if (live > 0)
                            live--;
                    end
                end
            end
            default: ;
        endcase
        r.live  = live;
        r.empty = (live == 0);
        r.full  = (live == n);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        slab_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < SLAB_DEPTH; i++)
                link_mem[i] = '0;
            head      = COUNT_W'(SLAB_DEPTH);
            live      = '0;
            base_reg  = BASE_RESET;
            size_reg  = SIZE_RESET;
            count_reg = COUNT_RESET;
            expected_results.delete();
            errors    = 0;
        end else begin
            // compare first: a word taken on this edge has its result later
            if (done) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("unexpected result", 64'(status), 64'(0));
                end else begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        flag_mismatch("status", 64'(status), 64'(want.status));
                    if (object_address !== want.address)
                        flag_mismatch("object_address", 64'(object_address), 64'(want.address));
                    if (object_index !== want.index)
                        flag_mismatch("object_index", 64'(object_index), 64'(want.index));
                    if (allocated_count !== want.live)
                        flag_mismatch("allocated_count", 64'(allocated_count), 64'(want.live));
                    if (is_empty !== want.empty)
                        flag_mismatch("is_empty", 64'(is_empty), 64'(want.empty));
                    if (is_full !== want.full)
                        flag_mismatch("is_full", 64'(is_full), 64'(want.full));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_OBJECT_BASE:  base_reg  = cfg_data[BASE_W-1:0];
                    REG_OBJECT_SIZE:  size_reg  = cfg_data[SIZE_W-1:0];
                    REG_OBJECT_COUNT: count_reg = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_results.push_back(slab_apply(opcode, free_address));
        end
        outstanding <= expected_results.size();
        fail_count  <= errors;
    end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfla_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [OP_W-1:0]      OP_NOP    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   start        = 1'b0;
    logic [OP_W-1:0]        opcode       = '0;
    logic [BASE_W-1:0]      free_address = '0;
    logic                   cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   busy;
    logic                   done;
    logic [STATUS_W-1:0]    status;
    logic [BASE_W-1:0]      object_address;
    logic [INDEX_OUT_W-1:0] object_index;
    logic [COUNT_W-1:0]     allocated_count;
    logic                   is_empty;
    logic                   is_full;
    logic                   cfg_ready;
    int                     outstanding;
    int                     fail_count;

    // stimulus-side view of the active setting, for address generation
    logic [BASE_W-1:0] cur_base;
    int                cur_size;
    int                cur_count;
    bit                steady;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    slab_free_list_allocator_core dut (.*);

    slab_checker u_checker (.*);

    task automatic send_word(logic [OP_W-1:0] op, logic [BASE_W-1:0] addr);
        if (!steady && $urandom_range(99) < 10) begin
            start <= 1'b0;
            repeat ($urandom_range(32, 1)) @(posedge clk);
        end
        start        <= 1'b1;
        opcode       <= op;
        free_address <= addr;
        do @(posedge clk); while (busy);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (!steady && $urandom_range(99) < 10) begin
            cfg_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0 || busy);
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] bw, logic [CFG_DATA_W-1:0] sw,
                              logic [CFG_DATA_W-1:0] cw);
        wait_idle();
        write_reg(REG_OBJECT_BASE, bw);
        write_reg(REG_OBJECT_SIZE, sw);
        write_reg(REG_OBJECT_COUNT, cw);
        cfg_valid <= 1'b0;
        cur_base  = bw[BASE_W-1:0];
        cur_size  = (sw[SIZE_W-1:0] == 0) ? 1 : sw[SIZE_W-1:0];
        cur_count = (cw[COUNT_W-1:0] == 0) ? 1 :
                    ((cw[COUNT_W-1:0] > MAX_OBJECTS_DEF) ? MAX_OBJECTS_DEF : cw[COUNT_W-1:0]);
    endtask

    initial begin : stimulus
        int                    sent;
        int                    phase;
        int                    n_items;
        int                    alloc_pct;
        int                    pick;
        int                    k;
        longint unsigned       a;
        logic [OP_W-1:0]       op;
        logic [BASE_W-1:0]     addr;
        logic [CFG_DATA_W-1:0] bw;
        logic [CFG_DATA_W-1:0] sw;
        logic [CFG_DATA_W-1:0] cw;

        cur_base  = BASE_RESET;
        cur_size  = SIZE_RESET;
        cur_count = COUNT_RESET;
        steady    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: empty list before init, then the basic operations
        send_word(OP_ALLOC, 24'h5A5A5A);
        send_word(OP_FREE, 24'h000010);
        send_word(OP_ALLOC, 24'h000000);
        send_word(OP_INIT, 24'hFFFFFF);
        send_word(OP_ALLOC, 24'h000000);
        send_word(OP_ALLOC, 24'h000000);
        send_word(OP_FREE, 24'h000010);
        send_word(OP_FREE, 24'h000010);
        send_word(OP_FREE, 24'hFFFFFF);
        send_word(OP_FREE, 24'h000011);
        send_word(OP_NOP, 24'hA5A5A5);
        wait_idle();
        write_reg(REG_SPARE, 24'h3C3C3C);
        cfg_valid <= 1'b0;

        // top of the address space: second object wraps past 24 bits
        set_config(24'hFFFF00, 24'hA5FFFF, {15'h2D2D, 9'd2});
        send_word(OP_INIT, 24'h000000);
        send_word(OP_ALLOC, 24'h000000);
        send_word(OP_ALLOC, 24'h000000);
        send_word(OP_ALLOC, 24'h000000);
        send_word(OP_FREE, 24'hFFFF00);
        send_word(OP_FREE, 24'h000000);

        // zero size and zero count act as one
        set_config(24'h000000, 24'hFF0000, {15'h7FFF, 9'd0});
        send_word(OP_INIT, 24'h000000);
        send_word(OP_ALLOC, 24'h000000);
        send_word(OP_FREE, 24'h000001);
        send_word(OP_ALLOC, 24'h000000);

        // count above the slab clamps; then lower it under the head
        set_config(24'h000100, 24'h000001, 24'd300);
        send_word(OP_INIT, 24'h000000);
        send_word(OP_ALLOC, 24'h000000);
        send_word(OP_ALLOC, 24'h000000);
        set_config(24'h000100, 24'h000001, 24'd1);
        send_word(OP_ALLOC, 24'h000000);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            steady = (phase >= 8 && phase < 14);
            case ($urandom_range(5))
                0:       bw = '0;
                1:       bw = '1;
                default: bw = CFG_DATA_W'($urandom);
            endcase
            sw = CFG_DATA_W'($urandom);
            case ($urandom_range(9))
                0:       sw[SIZE_W-1:0] = '0;
                1:       sw[SIZE_W-1:0] = '1;
                2:       sw[SIZE_W-1:0] = SIZE_W'($urandom_range(65535, 1));
                default: sw[SIZE_W-1:0] = SIZE_W'($urandom_range(64, 1));
            endcase
            cw = CFG_DATA_W'($urandom);
            case ($urandom_range(9))
                0:       cw[COUNT_W-1:0] = '0;
                1:       cw[COUNT_W-1:0] = 9'd256;
                2:       cw[COUNT_W-1:0] = COUNT_W'($urandom_range(511, 257));
                3:       cw[COUNT_W-1:0] = 9'd1;
                default: cw[COUNT_W-1:0] = COUNT_W'($urandom_range(40, 2));
            endcase
            set_config(bw, sw, cw);
            // skip the init now and then so a lowered count leaves a stale head
            if (phase == 0 || $urandom_range(99) < 80) begin
                send_word(OP_INIT, BASE_W'($urandom));
                sent++;
            end
            n_items = $urandom_range(90, 30);
            case ($urandom_range(2))
                0:       alloc_pct = 25;
                1:       alloc_pct = 45;
                default: alloc_pct = 80;
            endcase
            repeat (n_items) begin
                pick = $urandom_range(99);
                addr = BASE_W'($urandom);
                if (pick < 3) begin
                    op = OP_NOP;
                end else if (pick < 6) begin
                    op = OP_INIT;
                end else if (pick < 6 + alloc_pct) begin
                    op = OP_ALLOC;
                end else begin
                    op   = OP_FREE;
                    k    = $urandom_range(cur_count - 1);
                    a    = cur_base + longint'(k) * cur_size;
                    pick = $urandom_range(99);
                    if (pick < 10 && cur_size > 1)
                        a += $urandom_range(cur_size - 1, 1);
                    else if (pick < 15)
                        a = cur_base + longint'(cur_count) * cur_size;
                    else if (pick < 20)
                        a = cur_base - 1;
                    else if (pick < 25)
                        a = $urandom;
                    addr = a[BASE_W-1:0];
                end
                send_word(op, addr);
                sent++;
            end
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[slab_free_list_allocator_core] OK");
        else
            $display("[slab_free_list_allocator_core] ERROR");
        $finish;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[slab_free_list_allocator_core] ERROR");
        $finish;
    end

endmodule
